// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL; every check is disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps

package sha256_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NUM_H    = 8;
    localparam int unsigned NUM_RND  = 64;
    localparam int unsigned BLOCK_W  = 512;
    localparam int unsigned FILL_W   = 6;
    localparam int unsigned RND_W    = 6;
    localparam int unsigned LEN_W    = 64;

    localparam logic [7:0]        PAD_BYTE  = 8'h80;
    localparam logic [FILL_W-1:0] FILL_LAST = 6'd63;
    localparam logic [FILL_W-1:0] FILL_LEN  = 6'd56;
    localparam logic [RND_W-1:0]  RND_LAST  = 6'd63;

    localparam logic [31:0] INIT_H [NUM_H] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [NUM_RND] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ZERO,
        S_LEN,
        S_INIT,
        S_ROUND,
        S_FOLD,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SRC_INPUT,
        SRC_PAD,
        SRC_ZERO,
        SRC_LEN
    } byte_src_t;

    typedef struct packed {
        logic      shift_byte;
        byte_src_t src;
        logic      count_bits;
        logic      load_work;
        logic      do_round;
        logic      fold_chain;
        logic      capture;
    } dp_cmd_t;

    typedef struct packed {
        logic fill_full;
        logic fill_at_len;
        logic round_last;
    } dp_status_t;

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
        rotr32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_datapath.sv =====
`timescale 1ns / 1ps

module sha256_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sha256_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    output sha256_pkg::dp_status_t status,
    output logic [63:0]          digest_w0,
    output logic [63:0]          digest_w1,
    output logic [63:0]          digest_w2,
    output logic [63:0]          digest_w3
);
    import sha256_pkg::*;

    logic [WORD_W-1:0]  chain_reg [NUM_H];
    logic [WORD_W-1:0]  v_reg [NUM_H];
    logic [BLOCK_W-1:0] blk_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [RND_W-1:0]   rnd_reg;
    logic [LEN_W-1:0]   bits_reg;
    logic [63:0]        digest_w0_reg;
    logic [63:0]        digest_w1_reg;
    logic [63:0]        digest_w2_reg;
    logic [63:0]        digest_w3_reg;

    logic [7:0]        byte_mux;
    logic [WORD_W-1:0] w0, w1, w9, w14;
    logic [WORD_W-1:0] sched_s0, sched_s1, w_new;
    logic [WORD_W-1:0] big_s0, big_s1, ch, maj, t1, t2;

    always_comb
    begin
        case (cmd.src)
            SRC_INPUT: byte_mux = data_byte;
            SRC_PAD:   byte_mux = PAD_BYTE;
            SRC_ZERO:  byte_mux = 8'h00;
            SRC_LEN:   byte_mux = bits_reg[LEN_W-1 -: 8];
            default:   byte_mux = 8'h00;
        endcase
    end

    // Message schedule window: the top word is W for the current round.
    assign w0  = blk_reg[BLOCK_W-1 -: WORD_W];
    assign w1  = blk_reg[BLOCK_W-1-WORD_W -: WORD_W];
    assign w9  = blk_reg[BLOCK_W-1-9*WORD_W -: WORD_W];
    assign w14 = blk_reg[BLOCK_W-1-14*WORD_W -: WORD_W];

    assign sched_s0 = rotr32(w1, 7) ^ rotr32(w1, 18) ^ (w1 >> 3);
    assign sched_s1 = rotr32(w14, 17) ^ rotr32(w14, 19) ^ (w14 >> 10);
    assign w_new    = w0 + sched_s0 + w9 + sched_s1;

    assign big_s1 = rotr32(v_reg[4], 6) ^ rotr32(v_reg[4], 11) ^ rotr32(v_reg[4], 25);
    assign big_s0 = rotr32(v_reg[0], 2) ^ rotr32(v_reg[0], 13) ^ rotr32(v_reg[0], 22);
    assign ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1     = v_reg[7] + big_s1 + ch + ROUND_K[rnd_reg] + w0;
    assign t2     = big_s0 + maj;

    assign status.fill_full   = (fill_reg == FILL_LAST);
    assign status.fill_at_len = (fill_reg == FILL_LEN);
    assign status.round_last  = (rnd_reg == RND_LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_H; i++)
            begin
                chain_reg[i] <= INIT_H[i];
            end
            fill_reg <= '0;
            rnd_reg  <= '0;
            bits_reg <= '0;
        end
        else
        begin
            if (cmd.shift_byte)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.count_bits)
            begin
                bits_reg <= bits_reg + LEN_W'(8);
            end
            else if (cmd.shift_byte && cmd.src == SRC_LEN)
            begin
                bits_reg <= {bits_reg[LEN_W-9:0], 8'h00};
            end
            else if (cmd.capture)
            begin
                bits_reg <= '0;
            end
            if (cmd.load_work)
            begin
                rnd_reg <= '0;
            end
            else if (cmd.do_round)
            begin
                rnd_reg <= rnd_reg + 1'b1;
            end
            if (cmd.fold_chain)
            begin
                for (int i = 0; i < NUM_H; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + v_reg[i];
                end
            end
            else if (cmd.capture)
            begin
                for (int i = 0; i < NUM_H; i++)
                begin
                    chain_reg[i] <= INIT_H[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.shift_byte)
        begin
            blk_reg <= {blk_reg[BLOCK_W-9:0], byte_mux};
        end
        else if (cmd.do_round)
        begin
            blk_reg <= {blk_reg[BLOCK_W-WORD_W-1:0], w_new};
        end

        if (cmd.load_work)
        begin
            for (int i = 0; i < NUM_H; i++)
            begin
                v_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.do_round)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end

        if (cmd.capture)
        begin
            digest_w0_reg <= {chain_reg[0], chain_reg[1]};
            digest_w1_reg <= {chain_reg[2], chain_reg[3]};
            digest_w2_reg <= {chain_reg[4], chain_reg[5]};
            digest_w3_reg <= {chain_reg[6], chain_reg[7]};
        end
    end

    assign digest_w0 = digest_w0_reg;
    assign digest_w1 = digest_w1_reg;
    assign digest_w2 = digest_w2_reg;
    assign digest_w3 = digest_w3_reg;

endmodule

// ===== sv/sha256_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sha256_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   byte_present,
    input  logic                   last_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    input  sha256_pkg::dp_status_t status,
    output sha256_pkg::dp_cmd_t    cmd
);
    import sha256_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        last_reg, last_next;
    logic        padded_reg, padded_next;
    logic        len_reg, len_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            padded_reg    <= 1'b0;
            len_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            padded_reg    <= padded_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        padded_next = padded_reg;
        len_next    = len_reg;
        cmd         = '0;
        cmd.src     = SRC_INPUT;
        in_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = last_item;
                    if (byte_present)
                    begin
                        cmd.shift_byte = 1'b1;
                        cmd.count_bits = 1'b1;
                    end
                    if (byte_present && status.fill_full)
                    begin
                        state_next = S_INIT;
                    end
                    else if (last_item)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.shift_byte = 1'b1;
                cmd.src        = SRC_PAD;
                padded_next    = 1'b1;
                state_next     = status.fill_full ? S_INIT : S_ZERO;
            end
            S_ZERO:
            begin
                if (status.fill_at_len)
                begin
                    state_next = S_LEN;
                end
                else
                begin
                    cmd.shift_byte = 1'b1;
                    cmd.src        = SRC_ZERO;
                    if (status.fill_full)
                    begin
                        state_next = S_INIT;
                    end
                end
            end
            S_LEN:
            begin
                cmd.shift_byte = 1'b1;
                cmd.src        = SRC_LEN;
                if (status.fill_full)
                begin
                    len_next   = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.load_work = 1'b1;
                state_next    = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (status.round_last)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                cmd.fold_chain = 1'b1;
                if (!last_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (len_reg)
                begin
                    state_next = S_DONE;
                end
                else if (padded_reg)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    state_next = S_PAD;
                end
            end
            S_DONE:
            begin
                // Hold the digest until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.capture = 1'b1;
                    last_next   = 1'b0;
                    padded_next = 1'b0;
                    len_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.capture)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    `ASSERT_IMPL(a_capture_slot_free, clk, rst_n, cmd.capture, !out_valid_reg || out_ready)
    `ASSERT_NEXT(a_full_block_compresses, clk, rst_n,
        in_valid && in_ready && byte_present && status.fill_full, state_reg == S_INIT)
    `ASSERT_NEXT(a_rounds_then_fold, clk, rst_n,
        state_reg == S_ROUND && status.round_last, state_reg == S_FOLD)
    `ASSERT_IMPL(a_len_after_pad, clk, rst_n, state_reg == S_LEN, padded_reg && last_reg)

endmodule

// ===== sv/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps

// Channel | Handshake              | Payload
// input   | in_valid / in_ready    | data_byte[7:0], byte_present, last_item
// output  | out_valid / out_ready  | digest_w0..digest_w3 [63:0]
//
// One byte is taken per cycle while a block fills; a full block then runs
// a load step, 64 compression rounds and a fold step, with input stalled.
// Finishing writes the padding bytes with input stalled, runs one or two
// compressions and loads the digest register after the last fold, once it
// is free. The digest register lets the next message stream in while a
// digest waits; a second finish stalls only if that digest is still held.
// Reset loads the initial hash words and clears all counters at once.

module sha256_stream_hasher
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest_w0,
    output logic [63:0] digest_w1,
    output logic [63:0] digest_w2,
    output logic [63:0] digest_w3
);
    import sha256_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    sha256_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_present (byte_present),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .cmd          (cmd)
    );

    sha256_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .status    (status),
        .digest_w0 (digest_w0),
        .digest_w1 (digest_w1),
        .digest_w2 (digest_w2),
        .digest_w3 (digest_w3)
    );

endmodule

// ===== verif/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int TIMEOUT_NS     = 10_000_000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int HOLDOFF_CYCLES = 2500;
    localparam int ITEMS_TARGET   = 1600;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_OFFSET  = 56;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    localparam int SEND_IDLE [3] = '{33, 61, 0};
    localparam int RECV_IDLE [3] = '{61, 33, 0};

    // message lengths either side of the padding and block boundaries
    localparam int unsigned BOUNDARY_LENGTHS [6] = '{55, 56, 63, 64, 119, 120};

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // element 0 is digest_w0
    typedef logic [0:3][63:0] digest_t;

    localparam digest_t SHA_OF_EMPTY =
        256'he3b0c44298fc1c14_9afbf4c8996fb924_27ae41e4649b934c_a495991b7852b855;
    localparam digest_t SHA_OF_ABC =
        256'hba7816bf8f01cfea_414140de5dae2223_b00361a396177a9c_b410ff61f20015ad;
    localparam digest_t NO_DIGEST = '0;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       known;
        digest_t    known_digest;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 15;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, SHA_OF_EMPTY},   // empty message straight after reset
        '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},      // no byte, not last: ignored
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b1, 1'b1, SHA_OF_ABC},     // final byte rides on the last transfer
        '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h7f, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'ha5, 1'b0, 1'b1, 1'b0, NO_DIGEST},      // finish on held bytes, data ignored
        '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'hff, 1'b0, 1'b1, 1'b1, SHA_OF_EMPTY},
        '{8'h55, 1'b0, 1'b0, 1'b0, NO_DIGEST}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        last_item;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;

    // predictor state
    logic [31:0] hash_words [8];
    logic [7:0]  msg_block [BLOCK_BYTES];
    int unsigned block_fill;
    logic [63:0] bits_done;

    digest_t     pending_digests [$];
    digest_t     seen_digest;
    digest_t     oldest_digest;
    int unsigned fault_count;
    int unsigned items_sent;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned holdoff_requests;
    int unsigned holdoff_served;
    int unsigned holdoff_left;

    sha256_stream_hasher DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last_item    (last_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_w0    (digest_w0),
        .digest_w1    (digest_w1),
        .digest_w2    (digest_w2),
        .digest_w3    (digest_w3)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] both;
        both = {x, x} >> n;
        return both[31:0];
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_words[i] = IV_WORDS[i];
        for (int i = 0; i < BLOCK_BYTES; i++)
            msg_block[i] = 8'h00;
        block_fill = 0;
        bits_done  = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int i = 0; i < 16; i++)
            sched[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            sched[i] = sched[i-16] + sched[i-7]
                     + (ror32(sched[i-15], 7) ^ ror32(sched[i-15], 18) ^ (sched[i-15] >> 3))
                     + (ror32(sched[i-2], 17) ^ ror32(sched[i-2], 19) ^ (sched[i-2] >> 10));
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[i] + sched[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    // Returns 1 and the digest when the transfer finishes a message.
    function automatic bit absorb_item(input logic [7:0] b, input logic p, input logic l,
                                       output digest_t dg);
        int unsigned n;
        logic [63:0] total;
        if (p)
        begin
            msg_block[block_fill] = b;
            block_fill++;
            if (block_fill == BLOCK_BYTES)
            begin
                compress_block();
                bits_done += 64'd512;
                block_fill = 0;
            end
        end
        if (!l)
            return 1'b0;
        n = block_fill;
        total = bits_done + 64'(n) * 64'd8;
        msg_block[n] = PAD_MARK;
        n++;
        // no room left for the length: pad out and run an extra block
        if (n > LEN_OFFSET)
        begin
            while (n < BLOCK_BYTES)
            begin
                msg_block[n] = 8'h00;
                n++;
            end
            compress_block();
            n = 0;
        end
        while (n < LEN_OFFSET)
        begin
            msg_block[n] = 8'h00;
            n++;
        end
        for (int i = 0; i < 8; i++)
            msg_block[LEN_OFFSET + i] = total[63 - 8*i -: 8];
        compress_block();
        for (int i = 0; i < 4; i++)
            dg[i] = {hash_words[2*i], hash_words[2*i+1]};
        restart_hash();
        return 1'b1;
    endfunction

    task automatic send_item(input logic [7:0] b, input logic p, input logic l);
        int unsigned gap;
        digest_t dg;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        byte_present <= p;
        last_item    <= l;
        do
            @(posedge clk);
        while (!in_ready);
        if (absorb_item(b, p, l, dg))
            pending_digests.insert(pending_digests.size(), dg);
        if (p || l)
            items_sent++;
    endtask

    task automatic send_message(input int unsigned len);
        bit byte_on_last;
        byte_on_last = (len != 0) && ($urandom_range(1) == 1);
        for (int unsigned k = 0; k + byte_on_last < len; k++)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        end
        send_item(8'($urandom_range(255)), byte_on_last, 1'b1);
    endtask

    function automatic int unsigned pick_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return $urandom_range(0, 12);
        else if (sel < 78)
            return $urandom_range(50, 72);
        else if (sel < 95)
            return $urandom_range(0, 140);
        else
            return $urandom_range(180, 260);
    endfunction

    // Drop valid and hold until every digest owed has come out.
    task automatic drain_digests();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_digests.size() != 0);
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_valid         = 1'b0;
        data_byte        = 8'h00;
        byte_present     = 1'b0;
        last_item        = 1'b0;
        fault_count      = 0;
        items_sent       = 0;
        holdoff_requests = 0;
        send_idle_pct    = SEND_IDLE[0];
        recv_idle_pct    = RECV_IDLE[0];
        restart_hash();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_item(DIRECTED[r].data, DIRECTED[r].present, DIRECTED[r].last);
            if (DIRECTED[r].known)
                pending_digests[$] = DIRECTED[r].known_digest;
        end
        drain_digests();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            recv_idle_pct = RECV_IDLE[ph];
            if (ph == 0)
                foreach (BOUNDARY_LENGTHS[i])
                    send_message(BOUNDARY_LENGTHS[i]);
            // keep offering short messages while the receiver holds off
            if (ph == 2)
            begin
                holdoff_requests++;
                repeat (6) send_message($urandom_range(0, 3));
            end
            while (items_sent < ITEMS_TARGET * (ph + 1) / 3)
                send_message(pick_length());
            drain_digests();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_digests.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        out_ready      = 1'b0;
        holdoff_served = 0;
        holdoff_left   = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                out_ready <= 1'b0;
            end
            else if (holdoff_served != holdoff_requests)
            begin
                holdoff_served++;
                holdoff_left = HOLDOFF_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_digest = {digest_w0, digest_w1, digest_w2, digest_w3};
            if (pending_digests.size() == 0)
            begin
                $display("%0t: unexpected digest, expected none, actual %h", $time, seen_digest);
                fault_count++;
            end
            else
            begin
                oldest_digest = pending_digests.pop_front();
                for (int i = 0; i < 4; i++)
                    if (seen_digest[i] !== oldest_digest[i])
                    begin
                        $display("%0t: digest_w%0d expected %h actual %h",
                                 $time, i, oldest_digest[i], seen_digest[i]);
                        fault_count++;
                    end
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

endmodule
